// ===== sv/vphb_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity PID H-bridge drive package
// Shared widths, constants, register indexes and width helpers.
// ----------------------------------------------------------------------------
package vphb_pkg;

  localparam int VPHB_SPEED_WIDTH = 16;
  localparam int VPHB_SUM_WIDTH   = 32;

  localparam int GAIN_W   = 16;
  localparam int DIR_W    = 2;
  localparam int DUTY_W   = 14;
  localparam int MAG_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = GAIN_W;

  // Integral operand is clamped to magnitude 2^40, so 42 signed bits suffice.
  localparam int CLAMP_BITS = 42;
  localparam int CLAMP_EXP  = 40;

  localparam logic [DUTY_W-1:0] FULL_DUTY   = 14'd10000;
  localparam logic [DUTY_W-1:0] DUTY_SCALE  = 14'd10000;
  localparam logic [15:0]       ROUND_HALF  = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P    = 2'd0,
    CFG_GAIN_I    = 2'd1,
    CFG_GAIN_D    = 2'd2,
    CFG_DIRECTION = 2'd3
  } cfg_index_t;

  // Width of the integral operand after the clamp.
  function automatic int clamp_w(input int sum_w);
    clamp_w = (sum_w > CLAMP_BITS) ? CLAMP_BITS : sum_w;
  endfunction

  // Width of the weighted sum, with headroom for two adds and a negate.
  function automatic int raw_w(input int speed_w, input int sum_w);
    int pi_w;
    int pd_w;
    pi_w  = clamp_w(sum_w) + GAIN_W + 1;
    pd_w  = speed_w + 2 + GAIN_W + 1;
    raw_w = ((pi_w > pd_w) ? pi_w : pd_w) + 2;
  endfunction

endpackage

// ===== sv/vphb_state.sv =====
// ----------------------------------------------------------------------------
// Velocity PID error state
// Holds target, error total and last error; registers error terms per item.
// ----------------------------------------------------------------------------
module vphb_state #(
  parameter int SPEED_WIDTH = vphb_pkg::VPHB_SPEED_WIDTH,
  parameter int SUM_WIDTH   = vphb_pkg::VPHB_SUM_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SPEED_WIDTH-1:0]           target_speed,
  input  logic signed [SPEED_WIDTH-1:0]           measured_speed,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SPEED_WIDTH:0]             err_q,
  output logic signed [vphb_pkg::clamp_w(SUM_WIDTH)-1:0] tot_q,
  output logic signed [SPEED_WIDTH+1:0]           diff_q
);
  import vphb_pkg::*;

  localparam int ERR_W   = SPEED_WIDTH + 1;
  localparam int ADD_W   = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;
  localparam int EXT_W   = (SUM_WIDTH > CLAMP_BITS) ? SUM_WIDTH : CLAMP_BITS;
  localparam int CLAMP_W = clamp_w(SUM_WIDTH);

  localparam logic signed [ADD_W-1:0] SUM_MAX =
    (ADD_W'(1) << (SUM_WIDTH - 1)) - ADD_W'(1);
  localparam logic signed [ADD_W-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [EXT_W-1:0] CLAMP_HI = EXT_W'(1) << CLAMP_EXP;
  localparam logic signed [EXT_W-1:0] CLAMP_LO = -CLAMP_HI;

  logic signed [SPEED_WIDTH-1:0] stored_target;
  logic signed [SUM_WIDTH-1:0]   error_total;
  logic signed [ERR_W-1:0]       last_error;

  logic                          accept;
  logic                          target_zero;
  logic                          target_changed;
  logic signed [SUM_WIDTH-1:0]   total_base;
  logic signed [ERR_W-1:0]       last_base;
  logic signed [ERR_W-1:0]       err;
  logic signed [ADD_W-1:0]       total_wide;
  logic signed [SUM_WIDTH-1:0]   total_sat;
  logic signed [EXT_W-1:0]       total_ext;
  logic signed [EXT_W-1:0]       total_clamped;
  logic signed [SPEED_WIDTH+1:0] diff;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    target_zero    = (target_speed == '0);
    target_changed = (target_speed != stored_target);
    total_base     = target_changed ? '0 : error_total;
    last_base      = target_changed ? '0 : last_error;
    err            = ERR_W'(target_speed) - ERR_W'(measured_speed);
    total_wide     = ADD_W'(total_base) + ADD_W'(err);
    if (total_wide > SUM_MAX) begin
      total_sat = SUM_MAX[SUM_WIDTH-1:0];
    end else if (total_wide < SUM_MIN) begin
      total_sat = SUM_MIN[SUM_WIDTH-1:0];
    end else begin
      total_sat = total_wide[SUM_WIDTH-1:0];
    end
    total_ext = EXT_W'(total_sat);
    if (total_ext > CLAMP_HI) begin
      total_clamped = CLAMP_HI;
    end else if (total_ext < CLAMP_LO) begin
      total_clamped = CLAMP_LO;
    end else begin
      total_clamped = total_ext;
    end
    diff = (SPEED_WIDTH + 2)'(err) - (SPEED_WIDTH + 2)'(last_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_target <= '0;
      error_total   <= '0;
      last_error    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        stored_target <= target_speed;
        error_total   <= target_zero ? '0 : total_sat;
        last_error    <= target_zero ? '0 : err;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  // A zero target feeds zero terms, which yields an all-zero result.
  always_ff @(posedge clk) begin
    if (accept) begin
      err_q  <= target_zero ? '0 : err;
      tot_q  <= target_zero ? '0 : total_clamped[CLAMP_W-1:0];
      diff_q <= target_zero ? '0 : diff;
    end
  end

`ifndef SYNTH
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    accept && target_zero |=> error_total == '0 && last_error == '0)
    else $error("zero target did not clear the error state");

  a_new_target_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && target_changed && !target_zero |=> error_total == $past(total_wide) ||
      error_total == SUM_MAX[SUM_WIDTH-1:0] || error_total == SUM_MIN[SUM_WIDTH-1:0])
    else $error("error total not restarted on a new target");
`endif

endmodule

// ===== sv/vphb_terms.sv =====
// ----------------------------------------------------------------------------
// Velocity PID weighted terms
// Multiplies the three error terms by their gains and sums the products.
// ----------------------------------------------------------------------------
module vphb_terms #(
  parameter int SPEED_WIDTH = vphb_pkg::VPHB_SPEED_WIDTH,
  parameter int SUM_WIDTH   = vphb_pkg::VPHB_SUM_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [vphb_pkg::GAIN_W-1:0]             gain_proportional,
  input  logic [vphb_pkg::GAIN_W-1:0]             gain_integral,
  input  logic [vphb_pkg::GAIN_W-1:0]             gain_derivative,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SPEED_WIDTH:0]             err_q,
  input  logic signed [vphb_pkg::clamp_w(SUM_WIDTH)-1:0] tot_q,
  input  logic signed [SPEED_WIDTH+1:0]           diff_q,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [vphb_pkg::raw_w(SPEED_WIDTH, SUM_WIDTH)-1:0] raw_q
);
  import vphb_pkg::*;

  localparam int RAW_W = raw_w(SPEED_WIDTH, SUM_WIDTH);
  localparam int PE_W  = SPEED_WIDTH + 1 + GAIN_W + 1;
  localparam int PI_W  = clamp_w(SUM_WIDTH) + GAIN_W + 1;
  localparam int PD_W  = SPEED_WIDTH + 2 + GAIN_W + 1;

  logic                   prod_valid;
  logic                   prod_ready;
  logic signed [PE_W-1:0] prod_e;
  logic signed [PI_W-1:0] prod_i;
  logic signed [PD_W-1:0] prod_d;

  assign prod_ready = !out_valid || out_ready;
  assign in_ready   = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        prod_valid <= in_valid;
      end
      if (prod_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_e <= PE_W'($signed({1'b0, gain_proportional}) * err_q);
      prod_i <= PI_W'($signed({1'b0, gain_integral}) * tot_q);
      prod_d <= PD_W'($signed({1'b0, gain_derivative}) * diff_q);
    end
    if (prod_valid && prod_ready) begin
      raw_q <= RAW_W'(prod_e) + RAW_W'(prod_i) + RAW_W'(prod_d);
    end
  end

endmodule

// ===== sv/vphb_duty.sv =====
// ----------------------------------------------------------------------------
// Velocity PID duty output
// Picks the bridge channel, scales the magnitude to hundredths, saturates.
// ----------------------------------------------------------------------------
module vphb_duty #(
  parameter int SPEED_WIDTH = vphb_pkg::VPHB_SPEED_WIDTH,
  parameter int SUM_WIDTH   = vphb_pkg::VPHB_SUM_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic signed [vphb_pkg::DIR_W-1:0]       direction_sign,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [vphb_pkg::raw_w(SPEED_WIDTH, SUM_WIDTH)-1:0] raw_q,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    drive_forward,
  output logic [vphb_pkg::DUTY_W-1:0]             duty_hundredths,
  output logic                                    duty_clipped
);
  import vphb_pkg::*;

  localparam int RAW_W  = raw_w(SPEED_WIDTH, SUM_WIDTH);
  localparam int PROD_W = MAG_W + DUTY_W;

  logic              mag_valid;
  logic              mag_ready;
  logic              mag_fwd;
  logic              mag_big;
  logic [MAG_W-1:0]  mag;

  logic              dir_zero;
  logic              raw_neg;
  logic [RAW_W-1:0]  raw_abs;
  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] rounded;
  logic [DUTY_W:0]   hundredths;
  logic              clip;

  assign mag_ready = !out_valid || out_ready;
  assign in_ready  = !mag_valid || mag_ready;

  always_comb begin
    dir_zero   = (direction_sign == '0);
    raw_neg    = raw_q[RAW_W-1];
    raw_abs    = raw_neg ? RAW_W'(-raw_q) : RAW_W'(raw_q);
    scaled     = PROD_W'(mag) * PROD_W'(DUTY_SCALE);
    rounded    = scaled + PROD_W'(ROUND_HALF);
    hundredths = rounded[PROD_W-1:16];
    clip       = mag_big || (hundredths > (DUTY_W + 1)'(FULL_DUTY));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mag_valid <= in_valid;
      end
      if (mag_ready) begin
        out_valid <= mag_valid;
      end
    end
  end

  // A reversed wiring flips which sign of the sum drives forward.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag_fwd <= !dir_zero && (raw_q != '0) && (raw_neg == direction_sign[DIR_W-1]);
      mag_big <= !dir_zero && (|raw_abs[RAW_W-1:MAG_W]);
      mag     <= dir_zero ? '0 : raw_abs[MAG_W-1:0];
    end
    if (mag_valid && mag_ready) begin
      drive_forward   <= mag_fwd;
      duty_hundredths <= clip ? FULL_DUTY : hundredths[DUTY_W-1:0];
      duty_clipped    <= clip;
    end
  end

`ifndef SYNTH
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_hundredths <= FULL_DUTY)
    else $error("duty above full scale");

  a_clip_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_clipped |-> duty_hundredths == FULL_DUTY)
    else $error("clipped duty not at full scale");

  a_big_clips: assert property (@(posedge clk) disable iff (rst)
    mag_valid && mag_ready && mag_big |=> duty_clipped)
    else $error("oversized magnitude not clipped");
`endif

endmodule

// ===== sv/velocity_pid_hbridge_drive.sv =====
// ----------------------------------------------------------------------------
// Velocity PID H-bridge drive
// Velocity PID loop whose output selects an H-bridge channel and a duty cycle.
// ----------------------------------------------------------------------------
// The input passes through the error-state, product, sum, magnitude and output
// registers in that order before m_tvalid rises.
// Throughput: one transfer per cycle, set by the update of the error state on
// each accepted input; the stages keep accepting input while a result waits,
// until all five are full.
// Reset (rst, synchronous) restores the default gains, clears state and
// empties the pipeline.
module velocity_pid_hbridge_drive #(
  parameter int SPEED_WIDTH = vphb_pkg::VPHB_SPEED_WIDTH,
  parameter int SUM_WIDTH   = vphb_pkg::VPHB_SUM_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_wen,
  input  logic [vphb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vphb_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Input stream.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata from bit 0: target_speed, measured_speed, zero padding.
  input  logic [((2 * SPEED_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // Result stream.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata from bit 0: drive_forward, duty_hundredths[13:0], duty_clipped.
  output logic [15:0]                            m_tdata
);
  import vphb_pkg::*;

  localparam int CLAMP_W = clamp_w(SUM_WIDTH);
  localparam int RAW_W   = raw_w(SPEED_WIDTH, SUM_WIDTH);

  // Configuration registers. The user must change them only while the block is
  // idle, which the block itself does not enforce; later stages read them directly.
  logic [GAIN_W-1:0]       gain_proportional;
  logic [GAIN_W-1:0]       gain_integral;
  logic [GAIN_W-1:0]       gain_derivative;
  logic signed [DIR_W-1:0] direction_sign;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= GAIN_W'(256);
      gain_integral     <= '0;
      gain_derivative   <= '0;
      direction_sign    <= DIR_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_GAIN_P:    gain_proportional <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:    gain_integral     <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:    gain_derivative   <= cfg_data[GAIN_W-1:0];
        CFG_DIRECTION: direction_sign    <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: error, saturated error total and error difference.
  logic                          st_valid;
  logic                          st_ready;
  logic signed [SPEED_WIDTH:0]   err_q;
  logic signed [CLAMP_W-1:0]     tot_q;
  logic signed [SPEED_WIDTH+1:0] diff_q;

  vphb_state #(
    .SPEED_WIDTH(SPEED_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .target_speed  (s_tdata[SPEED_WIDTH-1:0]),
    .measured_speed(s_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH]),
    .out_valid     (st_valid),
    .out_ready     (st_ready),
    .err_q         (err_q),
    .tot_q         (tot_q),
    .diff_q        (diff_q)
  );

  // Stages 2 and 3: gain products, then their sum in Q.16.
  logic                    raw_valid;
  logic                    raw_ready;
  logic signed [RAW_W-1:0] raw_q;

  vphb_terms #(
    .SPEED_WIDTH(SPEED_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_terms (
    .clk              (clk),
    .rst              (rst),
    .gain_proportional(gain_proportional),
    .gain_integral    (gain_integral),
    .gain_derivative  (gain_derivative),
    .in_valid         (st_valid),
    .in_ready         (st_ready),
    .err_q            (err_q),
    .tot_q            (tot_q),
    .diff_q           (diff_q),
    .out_valid        (raw_valid),
    .out_ready        (raw_ready),
    .raw_q            (raw_q)
  );

  // Stages 4 and 5: channel choice and magnitude, then scaling to
  // hundredths of a percent into the output register.
  logic              drive_forward;
  logic [DUTY_W-1:0] duty_hundredths;
  logic              duty_clipped;

  vphb_duty #(
    .SPEED_WIDTH(SPEED_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_duty (
    .clk            (clk),
    .rst            (rst),
    .direction_sign (direction_sign),
    .in_valid       (raw_valid),
    .in_ready       (raw_ready),
    .raw_q          (raw_q),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .drive_forward  (drive_forward),
    .duty_hundredths(duty_hundredths),
    .duty_clipped   (duty_clipped)
  );

  assign m_tdata = {duty_clipped, duty_hundredths, drive_forward};

endmodule
